### design/skse_pkg.sv
// Shared constants, codes and controller/datapath bundles for the sorted key set engine.
`default_nettype none

package skse_pkg;

    // Store size and field widths.
    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 27;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                rd_first;
        logic                scan;
        logic                ins_start;
        logic                ins_shift;
        logic                ins_put;
        logic                del_start;
        logic                del_shift;
        logic                del_end;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                respond;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_lt;
        logic hit;
        logic op_ins;
        logic op_del;
        logic count_zero;
        logic count_full;
        logic pos_last;
        logic shift_none;
        logic idx_last_up;
        logic idx_last_dn;
        logic rsp_free;
    } stat_t;

endpackage

`default_nettype wire

### design/skse_req_if.sv
// Request channel of the sorted key set engine: operation and key.
`default_nettype none

interface skse_req_if;
    logic                        valid;
    logic                        ready;
    logic [skse_pkg::OP_W-1:0]   op;
    logic [skse_pkg::KEY_W-1:0]  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

### design/skse_rsp_if.sv
// Response channel of the sorted key set engine: status and entry count.
`default_nettype none

interface skse_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skse_pkg::STATUS_W-1:0] status;
    logic [skse_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

### design/skse_dp.sv
// Datapath: key store memory, scan and shift counters, entry count and response register.
`default_nettype none

module skse_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire skse_pkg::cmd_t                cmd,
    output skse_pkg::stat_t                    stat,
    input  wire logic [skse_pkg::OP_W-1:0]     req_op,
    input  wire logic [skse_pkg::KEY_W-1:0]    req_key,
    input  wire logic                          rsp_ready,
    output logic                               rsp_valid,
    output logic [skse_pkg::STATUS_W-1:0]      rsp_status,
    output logic [skse_pkg::COUNT_W-1:0]       rsp_entry_count
);

    logic [skse_pkg::KEY_W-1:0]    mem [skse_pkg::CAPACITY];
    logic [skse_pkg::KEY_W-1:0]    rdata_reg;

    logic [skse_pkg::OP_W-1:0]     op_reg,     op_next;
    logic [skse_pkg::KEY_W-1:0]    key_reg,    key_next;
    logic [skse_pkg::CNT_W-1:0]    pos_reg,    pos_next;
    logic [skse_pkg::CNT_W-1:0]    idx_reg,    idx_next;
    logic [skse_pkg::CNT_W-1:0]    count_reg,  count_next;
    logic                          hit_reg,    hit_next;
    logic [skse_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                          rsp_valid_reg,  rsp_valid_next;
    logic [skse_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [skse_pkg::COUNT_W-1:0]  rsp_count_reg,  rsp_count_next;

    logic [skse_pkg::CNT_W-1:0]    rd_addr;
    logic [skse_pkg::CNT_W-1:0]    wr_addr;
    logic [skse_pkg::KEY_W-1:0]    wr_data;
    logic                          wr_en;
    logic                          rsp_free;

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // Read and write ports of the key store.
    always_comb
    begin
        rd_addr = '0;
        wr_addr = idx_reg;
        wr_data = rdata_reg;
        wr_en   = 1'b0;
        if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan)
        begin
            rd_addr = pos_reg + skse_pkg::CNT_W'(1);
        end
        else if (cmd.ins_start)
        begin
            rd_addr = count_reg - skse_pkg::CNT_W'(1);
        end
        else if (cmd.ins_shift)
        begin
            rd_addr = idx_reg - skse_pkg::CNT_W'(2);
            wr_en   = 1'b1;
        end
        else if (cmd.del_start)
        begin
            rd_addr = pos_reg + skse_pkg::CNT_W'(1);
        end
        else if (cmd.del_shift)
        begin
            rd_addr = idx_reg + skse_pkg::CNT_W'(2);
            wr_en   = 1'b1;
        end
        if (cmd.ins_put)
        begin
            wr_addr = pos_reg;
            wr_data = key_reg;
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[skse_pkg::ADDR_W-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr[skse_pkg::ADDR_W-1:0]];
    end

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        if (cmd.load)
        begin
            op_next  = req_op;
            key_next = req_key;
            pos_next = '0;
            hit_next = 1'b0;
        end
        if (cmd.scan)
        begin
            if (rdata_reg < key_reg)
            begin
                pos_next = pos_reg + skse_pkg::CNT_W'(1);
            end
            else
            begin
                hit_next = (rdata_reg == key_reg);
            end
        end
        if (cmd.ins_start)
        begin
            idx_next = count_reg;
        end
        if (cmd.ins_shift)
        begin
            idx_next = idx_reg - skse_pkg::CNT_W'(1);
        end
        if (cmd.del_start)
        begin
            idx_next = pos_reg;
        end
        if (cmd.del_shift)
        begin
            idx_next = idx_reg + skse_pkg::CNT_W'(1);
        end
        if (cmd.ins_put)
        begin
            count_next = count_reg + skse_pkg::CNT_W'(1);
        end
        if (cmd.del_end)
        begin
            count_next = count_reg - skse_pkg::CNT_W'(1);
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status;
        end

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.respond)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = status_reg;
            rsp_count_next  = skse_pkg::COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        status_reg     <= status_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        stat.key_lt      = (rdata_reg < key_reg);
        stat.hit         = hit_reg;
        stat.op_ins      = (op_reg == skse_pkg::OP_INSERT);
        stat.op_del      = (op_reg == skse_pkg::OP_DELETE);
        stat.count_zero  = (count_reg == '0);
        stat.count_full  = (count_reg == skse_pkg::CNT_W'(skse_pkg::CAPACITY));
        stat.pos_last    = (pos_reg + skse_pkg::CNT_W'(1) == count_reg);
        stat.shift_none  = (pos_reg == count_reg);
        stat.idx_last_up = (idx_reg == pos_reg + skse_pkg::CNT_W'(1));
        stat.idx_last_dn = (idx_reg + skse_pkg::CNT_W'(2) == count_reg);
        stat.rsp_free    = rsp_free;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_status      = rsp_status_reg;
    assign rsp_entry_count = rsp_count_reg;

endmodule

`default_nettype wire

### design/skse_ctrl.sv
// Controller: sequences the scan, the shift and the response for each request.
`default_nettype none

module skse_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire skse_pkg::stat_t stat,
    output skse_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_INS    = 4'd4;
    localparam logic [3:0] S_PUT    = 4'd5;
    localparam logic [3:0] S_DEL    = 4'd6;
    localparam logic [3:0] S_DEC    = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The entry at pos is compared while the next one is read.
                cmd.scan = 1'b1;
                if (!stat.key_lt || stat.pos_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_RESP;
                if (stat.op_ins)
                begin
                    if (stat.hit)
                    begin
                        cmd.status = skse_pkg::ST_MISS;
                    end
                    else if (stat.count_full)
                    begin
                        cmd.status = skse_pkg::ST_FULL;
                    end
                    else if (stat.shift_none)
                    begin
                        cmd.set_status = 1'b0;
                        state_next     = S_PUT;
                    end
                    else
                    begin
                        cmd.set_status = 1'b0;
                        cmd.ins_start  = 1'b1;
                        state_next     = S_INS;
                    end
                end
                else if (stat.op_del)
                begin
                    if (!stat.hit)
                    begin
                        cmd.status = skse_pkg::ST_MISS;
                    end
                    else if (stat.pos_last)
                    begin
                        cmd.set_status = 1'b0;
                        state_next     = S_DEC;
                    end
                    else
                    begin
                        cmd.set_status = 1'b0;
                        cmd.del_start  = 1'b1;
                        state_next     = S_DEL;
                    end
                end
                else
                begin
                    cmd.status = stat.hit ? skse_pkg::ST_OK : skse_pkg::ST_MISS;
                end
            end
            S_INS:
            begin
                cmd.ins_shift = 1'b1;
                if (stat.idx_last_up)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.ins_put    = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = skse_pkg::ST_OK;
                state_next     = S_RESP;
            end
            S_DEL:
            begin
                cmd.del_shift = 1'b1;
                if (stat.idx_last_dn)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.del_end    = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = skse_pkg::ST_OK;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                // Wait here only while the previous response is still unclaimed.
                if (stat.rsp_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/sorted_key_set_engine_unit.sv
// Sorted key set engine: ordered key store with member query, insert and delete requests.
// Each request scans the stored entries until its place is found; an insert or delete that changes the store
// then shifts the later entries and updates the entry count before the response is registered.
// A new request is taken only after the previous one has reached the response register.
// A response register lets the next request enter while the last response is still waiting.
// Reset clears the entry count and the response valid; the key store needs no clearing.
`default_nettype none

module sorted_key_set_engine_unit
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    skse_req_if.sink    req,
    skse_rsp_if.source  rsp
);

    skse_pkg::cmd_t  cmd;
    skse_pkg::stat_t stat;
    logic            ready;

    assign req.ready = ready;

    skse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skse_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_op          (req.op),
        .req_key         (req.key),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_entry_count (rsp.entry_count)
    );

endmodule

`default_nettype wire
